// ===== design/sliding_window_max_min_sum_unit_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SLIDING_WINDOW_MAX_MIN_SUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAX_MIN_SUM_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the antecedent.
`define SWMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/swmm_pkg.sv =====
package swmm_pkg;

   // Default sizes of the block.
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SUM_BITS_DEF    = 48;

   // Sample positions wrap at 16 bits.
   localparam int POS_BITS = 16;

   // Window size register.
   localparam int CFG_BITS = 7;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd4;

   // Handoff from the sequencer to the accumulator and the output register.
   typedef struct packed {
      logic fire;
      logic final_win;
   } swmm_ctl_type;

   // Bits of one queue slot index.
   function automatic int slot_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== design/swmm_ram.sv =====
module swmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/swmm_acc.sv =====
module swmm_acc import swmm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = SUM_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swmm_ctl_type               ctl,
   input  logic signed [SAMPLE_BITS-1:0] max_val,
   input  logic signed [SAMPLE_BITS-1:0] min_val,
   output logic signed [SUM_BITS-1:0]    sum_next
);

   localparam int D_BITS = SAMPLE_BITS + 1;
   localparam int WB = ((SUM_BITS > D_BITS) ? SUM_BITS : D_BITS) + 1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [D_BITS-1:0]   pair_sum;
   logic signed [WB-1:0]       wide_sum;
   logic [WB-SUM_BITS:0]       top_bits;
   logic                       in_range;

   // Add max plus min to the running sum with headroom, then clamp.
   always_comb begin
      pair_sum = D_BITS'(max_val) + D_BITS'(min_val);
      wide_sum = WB'(sum_ff) + WB'(pair_sum);
      top_bits = wide_sum[WB-1:SUM_BITS-1];
      in_range = (&top_bits) | ~(|top_bits);
      if (in_range) begin
         sum_next = wide_sum[SUM_BITS-1:0];
      end else if (wide_sum[WB-1]) begin
         sum_next = SUM_MIN;
      end else begin
         sum_next = SUM_MAX;
      end
   end

   // The sum restarts after the last sample of a sequence.
   always_comb begin
      sum_in = sum_ff;
      if (ctl.fire && ctl.final_win) begin
         sum_in = '0;
      end else if (ctl.fire) begin
         sum_in = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== design/swmm_ctrl.sv =====
module swmm_ctrl import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SLOT_BITS  = slot_bits(WINDOW_MAX),
   localparam int ADDR_BITS  = SLOT_BITS + 1,
   localparam int ENTRY_BITS = SAMPLE_BITS + POS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   output logic                          busy,
   input  logic [CFG_BITS-1:0]           window_size,
   input  logic                          out_free,
   output logic                          ram_wr_en,
   output logic [ADDR_BITS-1:0]          ram_addr,
   output logic [ENTRY_BITS-1:0]         ram_wr_data,
   input  logic [ENTRY_BITS-1:0]         ram_rd_data,
   output logic signed [SAMPLE_BITS-1:0] max_front,
   output logic signed [SAMPLE_BITS-1:0] min_front,
   output swmm_ctl_type                  ctl
);

   localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
   localparam int CMP_BITS = (SAMPLE_BITS > POS_BITS) ? SAMPLE_BITS : POS_BITS;
   localparam logic [SLOT_BITS:0]   WM_SLOT  = (SLOT_BITS+1)'(WINDOW_MAX);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_MAX - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_F_RD  = 3'd1;
   localparam logic [2:0] ST_F_CHK = 3'd2;
   localparam logic [2:0] ST_B_RD  = 3'd3;
   localparam logic [2:0] ST_B_CHK = 3'd4;
   localparam logic [2:0] ST_WR    = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic                         qsel_ff, qsel_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                         last_ff, last_in;
   logic [CFG_BITS-1:0]          k_ff, k_in;
   logic [POS_BITS-1:0]          pos_ff, pos_in;
   logic                         full_ff, full_in;
   logic [SLOT_BITS-1:0]         max_head_ff, max_head_in;
   logic [SLOT_BITS-1:0]         min_head_ff, min_head_in;
   logic [CNT_BITS-1:0]          max_cnt_ff, max_cnt_in;
   logic [CNT_BITS-1:0]          min_cnt_ff, min_cnt_in;
   logic signed [SAMPLE_BITS-1:0] hold_ff, hold_in;
   logic signed [SAMPLE_BITS-1:0] max_front_ff, max_front_in;
   logic signed [SAMPLE_BITS-1:0] min_front_ff, min_front_in;

   logic [SLOT_BITS-1:0] head_sel, head_inc, head_nxt, offset;
   logic [CNT_BITS-1:0]  cnt_sel, cnt_nxt;
   logic [SLOT_BITS:0]   slot_sum, slot_wrap;
   logic [SAMPLE_BITS-1:0] rd_val;
   logic [POS_BITS-1:0]  rd_pos, age;
   logic [SAMPLE_BITS-1:0] samp_off, rd_off;
   logic [CMP_BITS-1:0]  cmp_a, cmp_b;
   logic                 pop;
   logic                 full_hit;
   logic                 clear_all;
   logic signed [SAMPLE_BITS-1:0] front_val;

   // Pointers of the queue now being worked on.
   assign head_sel = qsel_ff ? min_head_ff : max_head_ff;
   assign cnt_sel  = qsel_ff ? min_cnt_ff : max_cnt_ff;
   assign head_inc = (head_sel == LAST_SLOT) ? '0 : head_sel + 1'b1;

   // Circular slot address: the front, the back entry, or the free slot.
   always_comb begin
      case (state_ff)
         ST_B_RD: offset = SLOT_BITS'(cnt_sel - 1'b1);
         ST_WR:   offset = SLOT_BITS'(cnt_sel);
         default: offset = '0;
      endcase
      slot_sum  = {1'b0, head_sel} + {1'b0, offset};
      slot_wrap = (slot_sum >= WM_SLOT) ? slot_sum - WM_SLOT : slot_sum;
   end

   assign ram_addr    = {qsel_ff, slot_wrap[SLOT_BITS-1:0]};
   assign ram_wr_data = {sample_ff, pos_ff};
   assign rd_val      = ram_rd_data[ENTRY_BITS-1:POS_BITS];
   assign rd_pos      = ram_rd_data[POS_BITS-1:0];
   assign age         = pos_ff - rd_pos;

   // Signed order becomes unsigned order once the sign bit is flipped.
   assign samp_off = {~sample_ff[SAMPLE_BITS-1], sample_ff[SAMPLE_BITS-2:0]};
   assign rd_off   = {~rd_val[SAMPLE_BITS-1], rd_val[SAMPLE_BITS-2:0]};

   // The one shared comparator: age against window at the front, values at the back.
   always_comb begin
      if (state_ff == ST_F_CHK) begin
         cmp_a = CMP_BITS'(age);
         cmp_b = CMP_BITS'(k_ff);
      end else if (!qsel_ff) begin
         cmp_a = CMP_BITS'(samp_off);
         cmp_b = CMP_BITS'(rd_off);
      end else begin
         cmp_a = CMP_BITS'(rd_off);
         cmp_b = CMP_BITS'(samp_off);
      end
      pop = (cmp_a >= cmp_b);
   end

   assign full_hit  = (pos_ff >= POS_BITS'(k_ff - 1'b1));
   assign front_val = (cnt_sel == '0) ? sample_ff : hold_ff;

   // Next state and next register values.
   always_comb begin
      state_in     = state_ff;
      qsel_in      = qsel_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      hold_in      = hold_ff;
      max_front_in = max_front_ff;
      min_front_in = min_front_ff;
      max_head_in  = max_head_ff;
      min_head_in  = min_head_ff;
      max_cnt_in   = max_cnt_ff;
      min_cnt_in   = min_cnt_ff;
      head_nxt     = head_sel;
      cnt_nxt      = cnt_sel;
      ram_wr_en    = 1'b0;
      ctl          = '0;
      clear_all    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               last_in   = req_last;
               qsel_in   = 1'b0;
               if (window_size == '0) begin
                  k_in = CFG_BITS'(1);
               end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
                  k_in = CFG_BITS'(WINDOW_MAX);
               end else begin
                  k_in = window_size;
               end
               state_in = ST_F_RD;
            end
         end
         ST_F_RD: begin
            state_in = (cnt_sel == '0) ? ST_WR : ST_F_CHK;
         end
         ST_F_CHK: begin
            if (pop) begin
               head_nxt = head_inc;
               cnt_nxt  = cnt_sel - 1'b1;
               state_in = ST_F_RD;
            end else begin
               hold_in  = rd_val;
               state_in = ST_B_RD;
            end
         end
         ST_B_RD: begin
            state_in = (cnt_sel == '0) ? ST_WR : ST_B_CHK;
         end
         ST_B_CHK: begin
            if (pop) begin
               cnt_nxt  = cnt_sel - 1'b1;
               state_in = ST_B_RD;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            ram_wr_en = 1'b1;
            cnt_nxt   = cnt_sel + 1'b1;
            if (!qsel_ff) begin
               max_front_in = front_val;
               qsel_in      = 1'b1;
               state_in     = ST_F_RD;
            end else begin
               min_front_in = front_val;
               full_in      = full_ff | full_hit;
               pos_in       = pos_ff + 1'b1;
               state_in     = (full_ff | full_hit | last_ff) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.fire      = 1'b1;
               ctl.final_win = last_ff;
               clear_all     = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write back the pointers of the active queue.
      if (qsel_ff) begin
         min_head_in = head_nxt;
         min_cnt_in  = cnt_nxt;
      end else begin
         max_head_in = head_nxt;
         max_cnt_in  = cnt_nxt;
      end

      // The last sample of a sequence empties both queues.
      if (clear_all) begin
         max_head_in = '0;
         min_head_in = '0;
         max_cnt_in  = '0;
         min_cnt_in  = '0;
         pos_in      = '0;
         full_in     = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         qsel_ff     <= 1'b0;
         pos_ff      <= '0;
         full_ff     <= 1'b0;
         max_head_ff <= '0;
         min_head_ff <= '0;
         max_cnt_ff  <= '0;
         min_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         qsel_ff     <= qsel_in;
         pos_ff      <= pos_in;
         full_ff     <= full_in;
         max_head_ff <= max_head_in;
         min_head_ff <= min_head_in;
         max_cnt_ff  <= max_cnt_in;
         min_cnt_ff  <= min_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      hold_ff      <= hold_in;
      max_front_ff <= max_front_in;
      min_front_ff <= min_front_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign max_front = max_front_ff;
   assign min_front = min_front_ff;

endmodule

// ===== design/sliding_window_max_min_sum_unit.sv =====
// Sliding-window maximum, minimum and saturating sum of max plus min over a
// stream of signed samples. Both monotonic queues live in one shared RAM with
// a single registered read port, and one comparator serves the front (age) and
// back (value) checks, so a request is worked on alone. For each queue in turn,
// the sequencer reads and checks the front, dropping aged-out entries, then
// reads and checks the back, dropping dominated entries, then writes the new
// entry; an empty queue goes straight to the write. A request also passes an
// accept state and, when it yields a result, an emit state that waits until
// the output register is free. Dropped entries average at most one per sample
// in each queue. req_stall stays high while a request is in work, and a
// finished result waits in the output register while the next request is
// accepted. Results start once window_size samples have been seen, or at a
// sample marked last, which also empties the queues and restarts the sum.
// The window size (0 is taken as 1, values above WINDOW_MAX as WINDOW_MAX)
// is to be written through the csr channel only while the block is idle;
// the block itself does not enforce this. It applies from the next request.
// There is no clearing pass after reset.
module sliding_window_max_min_sum_unit import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = SUM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_BITS-1:0]           csr_window_size,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   output logic signed [SUM_BITS-1:0]    rsp_running_sum,
   output logic                          rsp_final_window
);

   localparam int SLOT_BITS  = slot_bits(WINDOW_MAX);
   localparam int ADDR_BITS  = SLOT_BITS + 1;
   localparam int ENTRY_BITS = SAMPLE_BITS + POS_BITS;
   localparam int RAM_DEPTH  = 2 ** ADDR_BITS;

   logic [CFG_BITS-1:0]           cfg_ff, cfg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_min_ff;
   logic signed [SUM_BITS-1:0]    rsp_sum_ff;
   logic                          rsp_final_ff;

   logic                          out_free;
   logic                          ram_wr_en;
   logic [ADDR_BITS-1:0]          ram_addr;
   logic [ENTRY_BITS-1:0]         ram_wr_data, ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] max_front, min_front;
   logic signed [SUM_BITS-1:0]    sum_next;
   swmm_ctl_type                  ctl;

   // Window size register; always ready.
   assign csr_ready = 1'b1;
   assign cfg_in    = (csr_valid && csr_ready) ? csr_window_size : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Queue sequencer.
   swmm_ctrl #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_sample  (req_sample),
      .req_last    (req_last),
      .busy        (req_stall),
      .window_size (cfg_ff),
      .out_free    (out_free),
      .ram_wr_en   (ram_wr_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data),
      .max_front   (max_front),
      .min_front   (min_front),
      .ctl         (ctl)
   );

   // Both queues share one RAM; the top address bit picks the queue.
   swmm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Saturating running sum.
   swmm_acc #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .max_val  (max_front),
      .min_val  (min_front),
      .sum_next (sum_next)
   );

   // Output register.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = ctl.fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_max_ff   <= max_front;
         rsp_min_ff   <= min_front;
         rsp_sum_ff   <= sum_next;
         rsp_final_ff <= ctl.final_win;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_max   = rsp_max_ff;
   assign rsp_window_min   = rsp_min_ff;
   assign rsp_running_sum  = rsp_sum_ff;
   assign rsp_final_window = rsp_final_ff;

endmodule

// ===== design/swmm_checker.sv =====
`include "sliding_window_max_min_sum_unit_defines.svh"

module swmm_checker import swmm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = SUM_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   input logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   input logic signed [SUM_BITS-1:0]    rsp_running_sum,
   input logic                          rsp_final_window
);

   // A request holds the block for at least the next cycle.
   `SWMM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "no stall after request")

   // The window maximum never falls below the window minimum.
   `SWMM_ASSERT_NOW(a_max_ge_min, clock, reset, rsp_valid, rsp_window_max >= rsp_window_min, "max below min")

   // A new result only comes out of a request that was in work.
   `SWMM_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without work")

   // A stalled result holds.
   `SWMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_running_sum) && $stable(rsp_final_window), "stalled result changed")

endmodule

bind sliding_window_max_min_sum_unit swmm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .SUM_BITS    (SUM_BITS)
) u_swmm_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
   import swmm_pkg::*;

   localparam int SBITS = SAMPLE_BITS_DEF;
   localparam int ABITS = SUM_BITS_DEF;

   // Cycles with no request, result or register write moving before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;

   // Wait for the last request to settle once every expected window has come out.
   localparam int SETTLE_CYCLES = 300;

   // Number of requests in the long back to back sequence.
   localparam int LONG_RUN = 60;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_NARROW,
      STYLE_RISING,
      STYLE_FALLING,
      STYLE_EXTREME
   } sample_style_type;

   typedef struct {
      logic signed [SBITS-1:0] value;
      logic [POS_BITS-1:0]     pos;
   } window_entry_type;

   typedef struct {
      logic signed [SBITS-1:0] window_max;
      logic signed [SBITS-1:0] window_min;
      logic signed [ABITS-1:0] running_sum;
      logic                    final_window;
   } window_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CFG_BITS-1:0]     csr_window_size;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [SBITS-1:0] req_sample;
   logic                    req_last;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [SBITS-1:0] rsp_window_max;
   logic signed [SBITS-1:0] rsp_window_min;
   logic signed [ABITS-1:0] rsp_running_sum;
   logic                    rsp_final_window;

   // Shadow state of the window tracker.
   window_entry_type        max_deque[$];
   window_entry_type        min_deque[$];
   logic [POS_BITS-1:0]     next_pos;
   logic signed [ABITS-1:0] sum_total;
   bit                      window_filled;
   logic [CFG_BITS-1:0]     window_reg;

   window_result_type       pending_windows[$];
   window_result_type       oldest_window;

   int error_count     = 0;
   int samples_sent    = 0;
   int windows_checked = 0;
   int sequences_ended = 0;
   int size_writes     = 0;
   int quiet_cycles    = 0;
   int hold_left       = 0;
   bit stall_enable    = 1'b0;

   sliding_window_max_min_sum_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_min   (rsp_window_min),
      .rsp_running_sum  (rsp_running_sum),
      .rsp_final_window (rsp_final_window)
   );

   always #5 clock = ~clock;

   // Window length as the block uses it: zero acts as one, and sizes are capped.
   function automatic int clamp_window(input logic [CFG_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
      return int'(size);
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic signed [SBITS-1:0] next_sample(input sample_style_type style,
                                                          input logic signed [SBITS-1:0] prev);
      int t;
      case (style)
         STYLE_NARROW: begin
            t = $urandom_range(0, 6);
            return SBITS'(t - 3);
         end
         STYLE_RISING:  return prev + SBITS'($urandom_range(0, 3));
         STYLE_FALLING: return prev - SBITS'($urandom_range(0, 3));
         STYLE_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return {1'b0, {(SBITS-1){1'b1}}};
               1:       return {1'b1, {(SBITS-1){1'b0}}};
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return SBITS'($urandom);
      endcase
   endfunction

   function automatic void clear_windows();
      max_deque.delete();
      min_deque.delete();
      next_pos      = '0;
      sum_total     = '0;
      window_filled = 1'b0;
   endfunction

   // Advance the shadow deques by one accepted request and queue the window it reports.
   task automatic update_windows(input logic signed [SBITS-1:0] value, input logic is_last);
      int                  span;
      logic [POS_BITS-1:0] age;
      longint              acc;
      longint              addend;
      longint              limit_hi;
      longint              limit_lo;
      window_entry_type    fresh;
      window_result_type   res;
      span     = clamp_window(window_reg);
      limit_hi = (longint'(1) <<< (ABITS - 1)) - 1;
      limit_lo = -limit_hi - 1;
      fresh.value = value;
      fresh.pos   = next_pos;

      // Entries that have aged out of the window leave from the front.
      while (max_deque.size() > 0) begin
         age = next_pos - max_deque[0].pos;
         if (age < span) break;
         max_deque.delete(0);
      end
      while (min_deque.size() > 0) begin
         age = next_pos - min_deque[0].pos;
         if (age < span) break;
         min_deque.delete(0);
      end

      // The new value displaces entries it dominates, equal ones included.
      while (max_deque.size() > 0 && max_deque[$].value <= value)
         max_deque.delete(max_deque.size() - 1);
      while (min_deque.size() > 0 && min_deque[$].value >= value)
         min_deque.delete(min_deque.size() - 1);
      max_deque.insert(max_deque.size(), fresh);
      min_deque.insert(min_deque.size(), fresh);

      // The full flag survives the position wrap.
      if (next_pos >= span - 1) window_filled = 1'b1;
      next_pos = next_pos + 1'b1;

      if (window_filled || is_last) begin
         res.window_max   = max_deque[0].value;
         res.window_min   = min_deque[0].value;
         addend = longint'(res.window_max) + longint'(res.window_min);
         acc    = longint'(sum_total);
         if (addend > 0 && acc > limit_hi - addend) acc = limit_hi;
         else if (addend < 0 && acc < limit_lo - addend) acc = limit_lo;
         else acc = acc + addend;
         sum_total        = ABITS'(acc);
         res.running_sum  = sum_total;
         res.final_window = is_last;
         pending_windows.insert(pending_windows.size(), res);
      end

      if (is_last) begin
         clear_windows();
         sequences_ended++;
      end
   endtask

   task automatic report_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("%s", what);
   endtask

   // Present one request and hold it until the block takes it.
   task automatic send_sample(input logic signed [SBITS-1:0] value, input logic is_last);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= value;
      req_last   <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_windows(value, is_last);
      samples_sent++;
   endtask

   // Drop valid for a number of cycles; zero keeps the next request back to back.
   task automatic req_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Withdraw the request, then wait until every expected window has come out
   // and the last request has settled.
   task automatic wait_idle();
      req_gap(1);
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_BITS-1:0] size);
      wait_idle();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_reg = size;
      size_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reset value of the window size, with both sample extremes.
   task automatic test_default_window();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
   endtask

   // Size zero acts as one, oversize acts as the maximum, and short sequences emit anyway.
   task automatic test_window_clamp();
      write_window(7'd0);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b0);
      send_sample(16'sd7, 1'b1);
      write_window(7'd127);
      send_sample(-16'sd5, 1'b1);
      send_sample(16'sd20, 1'b0);
      send_sample(16'sh8000, 1'b1);
   endtask

   // Equal values displace older entries; then the window shrinks mid-sequence.
   task automatic test_equal_and_resize();
      write_window(7'd3);
      send_sample(16'sd9, 1'b0);
      send_sample(16'sd9, 1'b0);
      send_sample(16'sd9, 1'b0);
      send_sample(-16'sd4, 1'b0);
      send_sample(16'sd9, 1'b0);
      write_window(7'd2);
      send_sample(16'sd3, 1'b0);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd2, 1'b1);
   endtask

   // One long sequence, back to back with no stalls.
   task automatic test_long_sequence();
      sample_style_type        style;
      logic signed [SBITS-1:0] prev;
      int                      i;
      write_window(7'd8);
      stall_enable = 1'b0;
      style = STYLE_UNIFORM;
      prev  = '0;
      for (i = 0; i < LONG_RUN; i++) begin
         if (i % 20 == 0) style = sample_style_type'($urandom_range(0, 4));
         prev = next_sample(style, prev);
         send_sample(prev, i == LONG_RUN - 1);
      end
      stall_enable = 1'b1;
   endtask

   // Random sequences over a series of window sizes; a phase may cut a sequence short,
   // so the next size takes over in the middle of it.
   task automatic test_random_sequences();
      int                      phase;
      int                      budget;
      int                      remaining;
      int                      span;
      bit                      idle_enable;
      logic [CFG_BITS-1:0]     size;
      sample_style_type        style;
      logic signed [SBITS-1:0] prev;
      logic signed [SBITS-1:0] value;
      remaining = 0;
      style     = STYLE_UNIFORM;
      prev      = '0;
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       size = 7'd1;
            1:       size = 7'd2;
            2:       size = 7'd64;
            3:       size = 7'd0;
            4:       size = 7'd65;
            5:       size = 7'd127;
            6:       size = CFG_BITS'($urandom_range(3, 16));
            7:       size = CFG_BITS'($urandom_range(0, 127));
            default: size = CFG_BITS'($urandom_range(1, 8));
         endcase
         write_window(size);
         span         = clamp_window(size);
         budget       = (span > 16) ? 60 : 150;
         idle_enable  = (phase % 4 != 1);
         stall_enable = (phase % 3 != 2);
         repeat (budget) begin
            if (remaining == 0) begin
               remaining = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(1, 3 * span + 5);
               style = sample_style_type'($urandom_range(0, 4));
               prev  = SBITS'($urandom);
            end
            // A few stray values break up the shaped runs.
            value = ($urandom_range(0, 7) == 0) ? SBITS'($urandom) : next_sample(style, prev);
            prev  = value;
            if (idle_enable) req_gap(pause_length());
            send_sample(value, remaining == 1);
            remaining--;
         end
      end
      stall_enable = 1'b1;
   endtask

   // Result side stalls in random bursts while enabled.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            n = (stall_enable && $urandom_range(0, 3) == 0) ? pause_length() : 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               hold_left = n - 1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare each accepted result with the oldest expected window.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_windows.size() == 0) begin
            report_failure($sformatf("Unexpected result: max %0d min %0d sum %0d final %0b",
                                     rsp_window_max, rsp_window_min, rsp_running_sum,
                                     rsp_final_window));
         end else begin
            oldest_window = pending_windows[0];
            pending_windows.delete(0);
            windows_checked++;
            if (rsp_window_max !== oldest_window.window_max ||
                rsp_window_min !== oldest_window.window_min ||
                rsp_running_sum !== oldest_window.running_sum ||
                rsp_final_window !== oldest_window.final_window) begin
               report_failure($sformatf(
                  "Mismatch at window %0d: expected max %0d min %0d sum %0d final %0b, %s",
                  windows_checked, oldest_window.window_max, oldest_window.window_min,
                  oldest_window.running_sum, oldest_window.final_window,
                  $sformatf("got max %0d min %0d sum %0d final %0b", rsp_window_max,
                            rsp_window_min, rsp_running_sum, rsp_final_window)));
            end
         end
      end
   end

   // Abandon the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles, %0d windows still expected.",
                  quiet_cycles, pending_windows.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_window_size = CFG_RESET;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_last        = 1'b0;
      window_reg      = CFG_RESET;
      clear_windows();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      stall_enable = 1'b1;

      test_default_window();
      test_window_clamp();
      test_equal_and_resize();
      test_long_sequence();
      test_random_sequences();

      req_gap(1);
      wait_idle();

      $display("Sent %0d samples in %0d finished sequences; checked %0d windows.",
               samples_sent, sequences_ended, windows_checked);
      $display("Made %0d window size writes (0 to 127) and ran one long back to back sequence.",
               size_writes);
      if (error_count == 0 && pending_windows.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/swmm_pkg.sv
design/swmm_ram.sv
design/swmm_acc.sv
design/swmm_ctrl.sv
design/sliding_window_max_min_sum_unit.sv
design/swmm_checker.sv
verif/tb_top.sv
